// File: rtl/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared types, widths and constants of the lidar scan deskew block.
// ----------------------------------------------------------------------------
package lsd_pkg;

    // Operation codes of the input transaction
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_POINT = 2'd2;

    // Defaults of the top-level parameters
    localparam int DEF_MAX_SCAN_POINTS     = 2048;
    localparam int DEF_SLOPE_FRACTION_BITS = 16;

    // Field widths
    localparam int POSE_W  = 16;
    localparam int CNT_W   = 12;
    localparam int IDX_W   = 11;
    localparam int DIFF_W  = 17;
    localparam int SLOPE_W = 32;
    localparam int OUT_W   = 18;

    // Clamped interpolated position, wide enough that the final clamp is unchanged
    localparam int POS_W = 20;

    // CORDIC datapath
    localparam int CORDIC_STAGES = 15;
    localparam int CW            = 36;
    localparam int ZW            = 17;
    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

    typedef struct packed {
        logic [1:0]              quad;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    last;
    } lsd_side_t;

    // Arctangent of 2^-i in binary angle units
    function automatic logic signed [ZW-1:0] atan_val(input int i);
        logic signed [ZW-1:0] v;
        begin
            case (i)
                0:       v = 17'sd8192;
                1:       v = 17'sd4836;
                2:       v = 17'sd2555;
                3:       v = 17'sd1297;
                4:       v = 17'sd651;
                5:       v = 17'sd326;
                6:       v = 17'sd163;
                7:       v = 17'sd81;
                8:       v = 17'sd41;
                9:       v = 17'sd20;
                10:      v = 17'sd10;
                11:      v = 17'sd5;
                12:      v = 17'sd3;
                13:      v = 17'sd1;
                14:      v = 17'sd1;
                default: v = 17'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: rtl/lsd_slope_div.sv
// ----------------------------------------------------------------------------
// lsd_slope_div
// Radix-2 restoring divider for one slope: (diff * 2^F) / count, truncated
// toward zero and saturated to 32 bits. Holds the slope until the next division ends.
// ----------------------------------------------------------------------------
module lsd_slope_div
    import lsd_pkg::*;
#(
    parameter int FRAC_W = DEF_SLOPE_FRACTION_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [DIFF_W-1:0]  diff,
    input  logic [CNT_W-1:0]          divisor,
    output logic                      busy,
    output logic signed [SLOPE_W-1:0] slope
);

    localparam int NUM_W  = DIFF_W + FRAC_W;
    localparam int ITER_W = $clog2(NUM_W + 1);
    localparam int EXT_W  = (NUM_W > 33) ? NUM_W : 33;

    logic                      busy_reg;
    logic [ITER_W-1:0]         cnt_reg;
    logic [NUM_W-1:0]          num_reg;
    logic [NUM_W-1:0]          quo_reg;
    logic [CNT_W-1:0]          rem_reg;
    logic [CNT_W-1:0]          div_reg;
    logic                      neg_reg;
    logic signed [SLOPE_W-1:0] slope_reg;

    logic [DIFF_W-1:0]         mag;
    logic [CNT_W:0]            rem_sh;
    logic                      fit;
    logic [EXT_W-1:0]          q_ext;
    logic signed [SLOPE_W-1:0] slope_next;

    // Magnitude of the difference
    assign mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    // One quotient bit per cycle while busy
    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign fit    = rem_sh >= {1'b0, div_reg};

    // Apply sign and saturate
    always_comb
    begin
        q_ext = EXT_W'(quo_reg);
        if (neg_reg)
        begin
            if (q_ext > EXT_W'(33'h0_8000_0000))
                slope_next = {1'b1, {(SLOPE_W-1){1'b0}}};
            else
                slope_next = SLOPE_W'(-q_ext[SLOPE_W-1:0]);
        end
        else
        begin
            if (q_ext > EXT_W'(33'h0_7FFF_FFFF))
                slope_next = {1'b0, {(SLOPE_W-1){1'b1}}};
            else
                slope_next = q_ext[SLOPE_W-1:0];
        end
    end

    // Control and slope state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            slope_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= ITER_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
            else
            begin
                busy_reg  <= 1'b0;
                slope_reg <= slope_next;
            end
        end
    end

    // Divider datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {mag, {FRAC_W{1'b0}}};
            quo_reg <= '0;
            rem_reg <= '0;
            div_reg <= divisor;
            neg_reg <= diff[DIFF_W-1];
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[NUM_W-2:0], fit};
            rem_reg <= fit ? CNT_W'(rem_sh - {1'b0, div_reg}) : rem_sh[CNT_W-1:0];
        end
    end

    assign busy  = busy_reg;
    assign slope = slope_reg;

endmodule

// File: rtl/lsd_interp.sv
// ----------------------------------------------------------------------------
// lsd_interp
// Four-stage front end: pose interpolation by point index, position clamp,
// beam angle and quadrant pre-rotation for the CORDIC.
// ----------------------------------------------------------------------------
module lsd_interp
    import lsd_pkg::*;
#(
    parameter int FRAC_W = DEF_SLOPE_FRACTION_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic [IDX_W-1:0]          idx,
    input  logic [15:0]               rng,
    input  logic [15:0]               bearing,
    input  logic                      last_in,
    input  logic signed [POSE_W-1:0]  start_x,
    input  logic signed [POSE_W-1:0]  start_y,
    input  logic signed [POSE_W-1:0]  start_a,
    input  logic signed [SLOPE_W-1:0] step_x,
    input  logic signed [SLOPE_W-1:0] step_y,
    input  logic signed [SLOPE_W-1:0] step_a,
    output logic                      out_valid,
    output logic signed [CW-1:0]      out_x0,
    output logic signed [ZW-1:0]      out_z,
    output lsd_side_t                 out_side
);

    localparam int PW = IDX_W + 1 + SLOPE_W;
    localparam int SW = PW + 1;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_W - 1);
    localparam logic signed [SW-1:0] PMAX = SW'((1 << (POS_W - 1)) - 1);
    localparam logic signed [SW-1:0] PMIN = -SW'(1 << (POS_W - 1));

    logic [3:0] v_reg;

    // Stage 1 registers
    logic [IDX_W-1:0]          s1_idx_reg;
    logic [15:0]               s1_rng_reg, s1_brg_reg;
    logic                      s1_last_reg;
    logic signed [POSE_W-1:0]  s1_sx_reg, s1_sy_reg, s1_sa_reg;
    logic signed [SLOPE_W-1:0] s1_kx_reg, s1_ky_reg, s1_ka_reg;

    // Stage 2 registers
    logic signed [PW-1:0]      s2_px_reg, s2_py_reg, s2_pa_reg;
    logic [31:0]               s2_x0_reg;
    logic [15:0]               s2_brg_reg;
    logic                      s2_last_reg;
    logic signed [POSE_W-1:0]  s2_sx_reg, s2_sy_reg, s2_sa_reg;

    // Stage 3 registers
    logic signed [SW-1:0]      s3_xi_reg, s3_yi_reg;
    logic [15:0]               s3_ti_reg;
    logic [31:0]               s3_x0_reg;
    logic [15:0]               s3_brg_reg;
    logic                      s3_last_reg;

    // Stage 4 registers
    logic signed [CW-1:0]      s4_x0_reg;
    logic signed [ZW-1:0]      s4_z_reg;
    lsd_side_t                 s4_side_reg;

    logic signed [PW-1:0]      off_x, off_y, off_a;
    logic [15:0]               beam_ang, shifted;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[2:0], in_valid};
    end

    // Stage 1: capture point and frame
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_idx_reg  <= idx;
            s1_rng_reg  <= rng;
            s1_brg_reg  <= bearing;
            s1_last_reg <= last_in;
            s1_sx_reg   <= start_x;
            s1_sy_reg   <= start_y;
            s1_sa_reg   <= start_a;
            s1_kx_reg   <= step_x;
            s1_ky_reg   <= step_y;
            s1_ka_reg   <= step_a;
        end
    end

    // Stage 2: index times slope, range times inverse gain
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_px_reg   <= $signed({1'b0, s1_idx_reg}) * s1_kx_reg;
            s2_py_reg   <= $signed({1'b0, s1_idx_reg}) * s1_ky_reg;
            s2_pa_reg   <= $signed({1'b0, s1_idx_reg}) * s1_ka_reg;
            s2_x0_reg   <= s1_rng_reg * INV_GAIN_Q16;
            s2_brg_reg  <= s1_brg_reg;
            s2_last_reg <= s1_last_reg;
            s2_sx_reg   <= s1_sx_reg;
            s2_sy_reg   <= s1_sy_reg;
            s2_sa_reg   <= s1_sa_reg;
        end
    end

    // Stage 3: round offsets and add to the start pose
    assign off_x = (s2_px_reg + HALF) >>> FRAC_W;
    assign off_y = (s2_py_reg + HALF) >>> FRAC_W;
    assign off_a = (s2_pa_reg + HALF) >>> FRAC_W;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_xi_reg   <= SW'(s2_sx_reg) + SW'(off_x);
            s3_yi_reg   <= SW'(s2_sy_reg) + SW'(off_y);
            s3_ti_reg   <= s2_sa_reg + off_a[15:0];
            s3_x0_reg   <= s2_x0_reg;
            s3_brg_reg  <= s2_brg_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // Stage 4: clamp position, beam angle and quadrant split
    assign beam_ang = s3_ti_reg - s3_brg_reg;
    assign shifted  = beam_ang + 16'd8192;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_x0_reg <= CW'(s3_x0_reg);
            s4_z_reg  <= $signed({3'b000, shifted[13:0]}) - 17'sd8192;
            s4_side_reg.quad <= shifted[15:14];
            s4_side_reg.last <= s3_last_reg;
            if (s3_xi_reg > PMAX)
                s4_side_reg.pos_x <= POS_W'(PMAX);
            else if (s3_xi_reg < PMIN)
                s4_side_reg.pos_x <= POS_W'(PMIN);
            else
                s4_side_reg.pos_x <= POS_W'(s3_xi_reg);
            if (s3_yi_reg > PMAX)
                s4_side_reg.pos_y <= POS_W'(PMAX);
            else if (s3_yi_reg < PMIN)
                s4_side_reg.pos_y <= POS_W'(PMIN);
            else
                s4_side_reg.pos_y <= POS_W'(s3_yi_reg);
        end
    end

    assign out_valid = v_reg[3];
    assign out_x0    = s4_x0_reg;
    assign out_z     = s4_z_reg;
    assign out_side  = s4_side_reg;

endmodule

// File: rtl/lsd_cordic.sv
// ----------------------------------------------------------------------------
// lsd_cordic
// Fifteen-stage rotation-mode CORDIC, one register stage per iteration,
// with the quadrant and position carried alongside.
// ----------------------------------------------------------------------------
module lsd_cordic
    import lsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] in_x,
    input  logic signed [ZW-1:0] in_z,
    input  lsd_side_t            in_side,
    output logic                 out_valid,
    output logic signed [CW-1:0] out_x,
    output logic signed [CW-1:0] out_y,
    output lsd_side_t            out_side
);

    logic [CORDIC_STAGES-1:0] v_reg;
    logic signed [CW-1:0]     x_reg [CORDIC_STAGES];
    logic signed [CW-1:0]     y_reg [CORDIC_STAGES];
    logic signed [ZW-1:0]     z_reg [CORDIC_STAGES];
    lsd_side_t                side_reg [CORDIC_STAGES];

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[CORDIC_STAGES-2:0], in_valid};
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic signed [CW-1:0] xp, yp;
        logic signed [ZW-1:0] zp;
        lsd_side_t            sp;

        if (i == 0)
        begin : g_first
            assign xp = in_x;
            assign yp = '0;
            assign zp = in_z;
            assign sp = in_side;
        end
        else
        begin : g_next
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign zp = z_reg[i-1];
            assign sp = side_reg[i-1];
        end

        // Rotate toward zero residual angle
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!zp[ZW-1])
                begin
                    x_reg[i] <= xp - (yp >>> i);
                    y_reg[i] <= yp + (xp >>> i);
                    z_reg[i] <= zp - atan_val(i);
                end
                else
                begin
                    x_reg[i] <= xp + (yp >>> i);
                    y_reg[i] <= yp - (xp >>> i);
                    z_reg[i] <= zp + atan_val(i);
                end
                side_reg[i] <= sp;
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STAGES-1];
    assign out_x     = x_reg[CORDIC_STAGES-1];
    assign out_y     = y_reg[CORDIC_STAGES-1];
    assign out_side  = side_reg[CORDIC_STAGES-1];

endmodule

// File: rtl/lidar_scan_deskew.sv
// ----------------------------------------------------------------------------
// lidar_scan_deskew
// Motion-compensated conversion of lidar scan points to world coordinates.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries three kinds of transaction:
// load start pose, load end pose with point count, and transform point.
// Only point transactions produce a result on the output channel
// (out_valid / out_stall): world_x, world_y and last_point.
// Points stream at one per cycle unless the input stalls; a point's result
// passes 4 interpolation stages, 15 CORDIC stages, and the round and
// final add stages. The end-pose transaction starts three parallel
// bit-serial slope dividers; the input stalls while they run (one quotient
// bit per cycle), so load the end pose before streaming the scan's points.
// The whole pipeline advances together; when the output register holds a
// result that the receiver stalls, every stage holds and in_stall rises.
// Bubbles do not propagate stalls: any empty output register lets the
// pipeline move.
// Reset clears the start pose and slopes to zero and the point count to one.
// ----------------------------------------------------------------------------
module lidar_scan_deskew
    import lsd_pkg::*;
#(
    parameter int MAX_SCAN_POINTS     = DEF_MAX_SCAN_POINTS,
    parameter int SLOPE_FRACTION_BITS = DEF_SLOPE_FRACTION_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              operation,
    input  logic signed [15:0]      pose_x,
    input  logic signed [15:0]      pose_y,
    input  logic signed [15:0]      pose_heading,
    input  logic [CNT_W-1:0]        scan_points,
    input  logic [IDX_W-1:0]        point_index,
    input  logic [15:0]             point_range,
    input  logic signed [15:0]      point_bearing,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] world_x,
    output logic signed [OUT_W-1:0] world_y,
    output logic                    last_point
);

    localparam logic signed [POS_W:0] OMAX = (POS_W+1)'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [POS_W:0] OMIN = -(POS_W+1)'(1 << (OUT_W - 1));

    logic adv, accept, div_start, div_busy;
    logic [2:0] busy_vec;

    logic signed [POSE_W-1:0]  start_x_reg, start_y_reg, start_a_reg;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [DIFF_W-1:0]  diff_x, diff_y, diff_a;
    logic [15:0]               dh;
    logic signed [SLOPE_W-1:0] step_x, step_y, step_a;

    logic                      it_valid;
    logic signed [CW-1:0]      it_x0;
    logic signed [ZW-1:0]      it_z;
    lsd_side_t                 it_side;

    logic                      co_valid;
    logic signed [CW-1:0]      co_x, co_y, map_x, map_y;
    lsd_side_t                 co_side;

    logic                      ra_valid_reg;
    logic signed [POS_W-1:0]   ra_cx_reg, ra_cy_reg;
    lsd_side_t                 ra_side_reg;

    logic                      out_valid_reg;
    logic signed [OUT_W-1:0]   world_x_reg, world_y_reg;
    logic                      last_reg;
    logic signed [POS_W:0]     sum_x, sum_y;

    // Handshake: the whole pipeline moves unless a result is held
    assign adv       = !out_valid_reg || !out_stall;
    assign div_busy  = |busy_vec;
    assign in_stall  = !adv || div_busy;
    assign accept    = in_valid && !in_stall;
    assign div_start = accept && operation == OP_END;

    // Clamp the point count to one .. MAX_SCAN_POINTS
    always_comb
    begin
        if (scan_points == '0)
            count_next = CNT_W'(1);
        else if (32'(scan_points) > MAX_SCAN_POINTS)
            count_next = CNT_W'(MAX_SCAN_POINTS);
        else
            count_next = scan_points;
    end

    // Start pose and point count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            start_a_reg <= '0;
            count_reg   <= CNT_W'(1);
        end
        else if (accept && operation == OP_START)
        begin
            start_x_reg <= pose_x;
            start_y_reg <= pose_y;
            start_a_reg <= pose_heading;
        end
        else if (div_start)
            count_reg <= count_next;
    end

    // Pose differences; heading wraps to a signed half turn
    assign diff_x = $signed({pose_x[15], pose_x}) - $signed({start_x_reg[15], start_x_reg});
    assign diff_y = $signed({pose_y[15], pose_y}) - $signed({start_y_reg[15], start_y_reg});
    assign dh     = pose_heading - start_a_reg;
    assign diff_a = $signed({dh[15], dh});

    lsd_slope_div #(.FRAC_W(SLOPE_FRACTION_BITS)) u_div_x (
        .clk(clk), .rst_n(rst_n), .start(div_start), .diff(diff_x),
        .divisor(count_next), .busy(busy_vec[0]), .slope(step_x)
    );

    lsd_slope_div #(.FRAC_W(SLOPE_FRACTION_BITS)) u_div_y (
        .clk(clk), .rst_n(rst_n), .start(div_start), .diff(diff_y),
        .divisor(count_next), .busy(busy_vec[1]), .slope(step_y)
    );

    lsd_slope_div #(.FRAC_W(SLOPE_FRACTION_BITS)) u_div_a (
        .clk(clk), .rst_n(rst_n), .start(div_start), .diff(diff_a),
        .divisor(count_next), .busy(busy_vec[2]), .slope(step_a)
    );

    lsd_interp #(.FRAC_W(SLOPE_FRACTION_BITS)) u_interp (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(accept && operation == OP_POINT),
        .idx(point_index), .rng(point_range), .bearing(point_bearing),
        .last_in(({1'b0, point_index} + CNT_W'(1)) == count_reg),
        .start_x(start_x_reg), .start_y(start_y_reg), .start_a(start_a_reg),
        .step_x(step_x), .step_y(step_y), .step_a(step_a),
        .out_valid(it_valid), .out_x0(it_x0), .out_z(it_z), .out_side(it_side)
    );

    lsd_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(it_valid), .in_x(it_x0), .in_z(it_z), .in_side(it_side),
        .out_valid(co_valid), .out_x(co_x), .out_y(co_y), .out_side(co_side)
    );

    // Undo the quadrant pre-rotation
    always_comb
    begin
        case (co_side.quad)
            2'd0:
            begin
                map_x = co_x;
                map_y = co_y;
            end
            2'd1:
            begin
                map_x = -co_y;
                map_y = co_x;
            end
            2'd2:
            begin
                map_x = -co_x;
                map_y = -co_y;
            end
            default:
            begin
                map_x = co_y;
                map_y = -co_x;
            end
        endcase
    end

    // Round stage: Q16 to millimeters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ra_valid_reg <= 1'b0;
        else if (adv)
            ra_valid_reg <= co_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ra_cx_reg   <= POS_W'((map_x + CW'(32768)) >>> 16);
            ra_cy_reg   <= POS_W'((map_y + CW'(32768)) >>> 16);
            ra_side_reg <= co_side;
        end
    end

    // Output stage: add position and saturate
    assign sum_x = (POS_W+1)'(ra_side_reg.pos_x) + (POS_W+1)'(ra_cx_reg);
    assign sum_y = (POS_W+1)'(ra_side_reg.pos_y) + (POS_W+1)'(ra_cy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= ra_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_reg <= ra_side_reg.last;
            if (sum_x > OMAX)
                world_x_reg <= OUT_W'(OMAX);
            else if (sum_x < OMIN)
                world_x_reg <= OUT_W'(OMIN);
            else
                world_x_reg <= OUT_W'(sum_x);
            if (sum_y > OMAX)
                world_y_reg <= OUT_W'(OMAX);
            else if (sum_y < OMIN)
                world_y_reg <= OUT_W'(OMIN);
            else
                world_y_reg <= OUT_W'(sum_y);
        end
    end

    assign out_valid  = out_valid_reg;
    assign world_x    = world_x_reg;
    assign world_y    = world_y_reg;
    assign last_point = last_reg;

    // The three dividers always run in lockstep
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        busy_vec == 3'b000 || busy_vec == 3'b111)
        else $error("slope dividers out of step");

    // An end-pose transaction starts the dividers
    a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_busy)
        else $error("divider did not start");

    // No transaction is taken while slopes are being computed
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> !accept)
        else $error("transaction accepted during slope division");

    // The point count never reaches zero
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0)
        else $error("point count is zero");

endmodule

// File: tb/sv/lidar_scan_deskew_tb.sv
// ----------------------------------------------------------------------------
// lidar_scan_deskew_tb
// Self-checking bench for the scan deskew block: a directed table of pose
// and point transactions, then random scans, each point checked against a
// bit-accurate interpolation and rotation model kept in the bench.
// ----------------------------------------------------------------------------
module lidar_scan_deskew_tb
    import lsd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PTS = 2048;
    localparam int FRAC    = 16;
    localparam int RANDOM_ITEMS = 850;

    // Operation code with no defined action
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] ph;
        logic [11:0] cnt;
        logic [10:0] idx;
        logic [15:0] rng;
        logic [15:0] brg;
        bit          known;
        logic [17:0] ex;
        logic [17:0] ey;
        logic        el;
    } stim_t;

    typedef struct {
        logic [17:0] wx;
        logic [17:0] wy;
        logic        last;
    } point_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] operation = OP_START;
    logic signed [15:0] pose_x = '0;
    logic signed [15:0] pose_y = '0;
    logic signed [15:0] pose_heading = '0;
    logic [CNT_W-1:0] scan_points = '0;
    logic [IDX_W-1:0] point_index = '0;
    logic [15:0] point_range = '0;
    logic signed [15:0] point_bearing = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [OUT_W-1:0] world_x;
    logic signed [OUT_W-1:0] world_y;
    logic last_point;

    // Bench copy of the scan frame
    longint frame_x, frame_y, frame_t;
    longint slope_x, slope_y, slope_t;
    longint frame_cnt;

    point_out_t expected_points[$];
    int errors = 0;
    int points_seen = 0;
    int scans_sent = 0;
    int stall_left = 0;
    bit quiet_phase = 0;
    bit hold_long = 0;

    lidar_scan_deskew dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint fshift(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -64'sd1 - ((-64'sd1 - v) >>> s);
    endfunction

    function automatic longint slope_of(longint diff, longint n);
        longint q;
        q = (diff * (64'sd1 <<< FRAC)) / n;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q;
    endfunction

    function automatic longint offset_at(longint idx, longint slope);
        return fshift(idx * slope + (64'sd1 <<< (FRAC - 1)), FRAC);
    endfunction

    function automatic logic [17:0] clamp18(longint v);
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        return v[17:0];
    endfunction

    // Reset the frame to its power-up values
    task automatic frame_reset();
        frame_x = 0; frame_y = 0; frame_t = 0;
        slope_x = 0; slope_y = 0; slope_t = 0;
        frame_cnt = 1;
    endtask

    // Update the frame and, for a point, predict its world coordinates
    function automatic bit deskew_point(stim_t s, output point_out_t r);
        longint n, dh, xi, yi, ti, x, y, dx, dy, cx, cy, z;
        int ang, sh, quad;
        int atan_q[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10,
                           5, 3, 1, 1};
        r = '{default: '0};
        case (s.op)
            OP_START:
            begin
                frame_x = $signed(s.px);
                frame_y = $signed(s.py);
                frame_t = $signed(s.ph);
                return 0;
            end
            OP_END:
            begin
                n = s.cnt;
                if (n == 0) n = 1;
                if (n > MAX_PTS) n = MAX_PTS;
                frame_cnt = n;
                dh = $signed(16'(longint'($signed(s.ph)) - frame_t));
                slope_x = slope_of(longint'($signed(s.px)) - frame_x, n);
                slope_y = slope_of(longint'($signed(s.py)) - frame_y, n);
                slope_t = slope_of(dh, n);
                return 0;
            end
            OP_POINT:
            begin
                xi = frame_x + offset_at(s.idx, slope_x);
                yi = frame_y + offset_at(s.idx, slope_y);
                ti = frame_t + offset_at(s.idx, slope_t);
                ang = (int'(ti & 16'hFFFF) - int'(s.brg)) & 16'hFFFF;
                sh = (ang + 8192) & 16'hFFFF;
                quad = sh >> 14;
                z = longint'(sh & 16'h3FFF) - 8192;
                x = longint'(s.rng) * 39797;
                y = 0;
                for (int i = 0; i < 15; i++)
                begin
                    dx = fshift(y, i);
                    dy = fshift(x, i);
                    if (z >= 0)
                    begin
                        x -= dx; y += dy; z -= atan_q[i];
                    end
                    else
                    begin
                        x += dx; y -= dy; z += atan_q[i];
                    end
                end
                case (quad)
                    0: begin cx = x;  cy = y;  end
                    1: begin cx = -y; cy = x;  end
                    2: begin cx = -x; cy = -y; end
                    default: begin cx = y; cy = -x; end
                endcase
                r.wx = clamp18(xi + fshift(cx + 32768, 16));
                r.wy = clamp18(yi + fshift(cy + 32768, 16));
                r.last = (longint'(s.idx) + 1 == frame_cnt);
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    function automatic stim_t mk(logic [1:0] op, int px, int py, int ph, int cnt,
                                 int idx, int rng, int brg);
        stim_t s;
        s = '{default: '0};
        s.op = op; s.px = 16'(px); s.py = 16'(py); s.ph = 16'(ph); s.cnt = 12'(cnt);
        s.idx = 11'(idx); s.rng = 16'(rng); s.brg = 16'(brg);
        return s;
    endfunction

    // Drive one transaction and wait until it is taken
    task automatic send(stim_t s);
        point_out_t r;
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= s.op;
        pose_x <= s.px; pose_y <= s.py; pose_heading <= s.ph;
        scan_points <= s.cnt; point_index <= s.idx;
        point_range <= s.rng; point_bearing <= s.brg;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (deskew_point(s, r))
        begin
            if (s.known)
            begin
                r.wx = s.ex; r.wy = s.ey; r.last = s.el;
            end
            expected_points.push_back(r);
        end
    endtask

    function automatic stim_t rand_point(int n);
        int idx;
        idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                          : $urandom_range(0, n - 1);
        return mk(OP_POINT, 0, 0, 0, 0, idx, $urandom_range(0, 65535),
                  $urandom_range(0, 65535));
    endfunction

    // Receiver: random stall bursts, one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_long)
            out_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!quiet_phase && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 14);
        end
        else
            out_stall <= 1'b0;
    end

    // Check each result taken against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_points.size() == 0)
            begin
                $error("result with no prediction pending");
                errors++;
            end
            else
            begin
                point_out_t e;
                e = expected_points.pop_front();
                points_seen++;
                if (world_x !== e.wx)
                begin
                    $error("world_x expected %0d got %0d", $signed(e.wx), world_x);
                    errors++;
                end
                if (world_y !== e.wy)
                begin
                    $error("world_y expected %0d got %0d", $signed(e.wy), world_y);
                    errors++;
                end
                if (last_point !== e.last)
                begin
                    $error("last_point expected %0b got %0b", e.last, last_point);
                    errors++;
                end
            end
        end
    end

    // Long hold-off counted in cycles
    initial
    begin
        wait (scans_sent == 3);
        hold_long = 1'b1;
        repeat (300) @(posedge clk);
        hold_long = 1'b0;
    end

    initial
    begin
        #100ms;
        $display("lidar_scan_deskew regression: fail");
        $finish;
    end

    initial
    begin
        stim_t dir[$];
        stim_t s;
        int n, waited;
        frame_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset frame, extremes, zero and oversized counts, unused op
        s = mk(OP_POINT, 0, 0, 0, 0, 0, 0, 0);
        s.known = 1'b1; s.ex = '0; s.ey = '0; s.el = 1'b1;
        dir.push_back(s);
        dir.push_back(mk(OP_POINT, 0, 0, 0, 0, 0, 1000, 0));
        dir.push_back(mk(OP_POINT, 0, 0, 0, 0, 2047, 65535, 16'h8000));
        dir.push_back(mk(OP_POINT, 0, 0, 0, 0, 5, 65535, 16'h4000));
        dir.push_back(mk(OP_POINT, 0, 0, 0, 0, 1, 40000, 16'h7FFF));
        dir.push_back(mk(OP_UNUSED, 16'h7FFF, 16'h7FFF, 16'h7FFF, 12'hFFF, 11'h7FF,
                         16'hFFFF, 16'hFFFF));
        dir.push_back(mk(OP_START, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0));
        dir.push_back(mk(OP_END, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 0, 0, 0));
        dir.push_back(mk(OP_POINT, 0, 0, 0, 0, 0, 65535, 16'h8000));
        dir.push_back(mk(OP_POINT, 0, 0, 0, 0, 2047, 65535, 16'h2000));
        dir.push_back(mk(OP_END, 16'h7FFF, 16'h8000, 16'h0100, 0, 0, 0, 0));
        dir.push_back(mk(OP_POINT, 0, 0, 0, 0, 2047, 65535, 0));
        dir.push_back(mk(OP_START, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0));
        dir.push_back(mk(OP_END, 16'h8000, 16'h8000, 16'h8001, 12'hFFF, 0, 0, 0));
        dir.push_back(mk(OP_POINT, 0, 0, 0, 0, 2047, 65535, 16'hFFFF));
        dir.push_back(mk(OP_POINT, 0, 0, 0, 0, 2046, 1234, 16'h5555));
        dir.push_back(mk(OP_END, 100, -200, 300, 2048, 0, 0, 0));
        dir.push_back(mk(OP_POINT, 0, 0, 0, 0, 2047, 5000, 16'hAAAA));
        dir.push_back(mk(OP_POINT, 0, 0, 0, 0, 1024, 5000, 16'h1234));
        foreach (dir[i]) send(dir[i]);

        // Random scans: start pose, end pose, then points
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            int pts;
            if (n > RANDOM_ITEMS * 4 / 5) quiet_phase = 1'b1;
            pts = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                              : $urandom_range(1, 40);
            send(mk(OP_START, $urandom, $urandom, $urandom, 0, 0, 0, 0));
            send(mk(OP_END, $urandom, $urandom, $urandom, pts, 0, 0, 0));
            if (pts == 0) pts = 1;
            if (pts > MAX_PTS) pts = MAX_PTS;
            n += 2;
            for (int k = 0; k < ((pts < 30) ? pts : 30); k++)
            begin
                s = rand_point(pts);
                if (k == 0 && pts > 30) s.idx = 11'(pts - 1);
                send(s);
                n++;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                send(mk(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom));
            end
            scans_sent++;
        end
        in_valid <= 1'b0;

        waited = 0;
        while (expected_points.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        if (expected_points.size() != 0)
        begin
            $error("%0d predicted points never arrived", expected_points.size());
            errors++;
        end
        $display("Covered %0d scans and %0d checked points, with stalls and unused-op noise.",
                 scans_sent, points_seen);
        if (errors == 0)
            $display("lidar_scan_deskew regression: pass");
        else
            $display("lidar_scan_deskew regression: fail");
        $finish;
    end

endmodule

// File: files.f
rtl/lsd_pkg.sv
rtl/lsd_slope_div.sv
rtl/lsd_interp.sv
rtl/lsd_cordic.sv
rtl/lidar_scan_deskew.sv
tb/sv/lidar_scan_deskew_tb.sv
